/* rtl/grammar_token_scanner_assert.svh */
// assertion macros for the scanner modules, used by the result queue
`ifndef GRAMMAR_TOKEN_SCANNER_ASSERT_SVH
`define GRAMMAR_TOKEN_SCANNER_ASSERT_SVH

// invariant checked at every clock edge outside reset
`define GTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication checked outside reset
`define GTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gts_pkg.sv */
// shared types and constants of the grammar token scanner
package gts_pkg;

  localparam int unsigned MaxRes    = 3;
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam int unsigned KindW     = 4;
  localparam int unsigned ResCntW   = 2;

  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChCr         = 8'h0D;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChColon      = 8'h3A;
  localparam logic [7:0] ChEquals     = 8'h3D;
  localparam logic [7:0] ChOpen       = 8'h7B;
  localparam logic [7:0] ChClose      = 8'h7D;
  localparam logic [7:0] ChBar        = 8'h7C;
  localparam logic [7:0] ChSemi       = 8'h3B;
  localparam logic [7:0] ChSquote     = 8'h27;
  localparam logic [7:0] ChDquote     = 8'h22;

  typedef enum logic [2:0] {
    ModeIdle   = 3'd0,
    ModeSpace  = 3'd1,
    ModeIdent  = 3'd2,
    ModeLit    = 3'd3,
    ModeColon1 = 3'd4,
    ModeColon2 = 3'd5
  } scan_mode_e;

  typedef enum logic [KindW-1:0] {
    TkText    = 4'd0,
    TkIdent   = 4'd1,
    TkLit     = 4'd2,
    TkOpen    = 4'd3,
    TkClose   = 4'd4,
    TkBar     = 4'd5,
    TkSemi    = 4'd6,
    TkAssign  = 4'd7,
    TkIllegal = 4'd8,
    TkEnd     = 4'd9
  } tok_kind_e;

  // results of one input transfer, in order
  typedef struct packed {
    logic [ResCntW-1:0]           cnt;
    logic [MaxRes-1:0][KindW-1:0] kind;
    logic [7:0]                   text;
  } dec_res_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [7:0]       text;
    logic             last;
  } res_entry_t;

endpackage

/* rtl/gts_decode.sv */
// per-byte scan state machine producing up to three results per transfer
module gts_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        input_byte_i,
  input  logic              end_of_text_i,
  output gts_pkg::dec_res_t res_o
);

  gts_pkg::scan_mode_e mode_q, mode_d;
  logic                quote_q, quote_d;

  logic                is_alpha, is_digit, is_space_any, is_ident_ch, lit_close;

  // token start decode of the current byte
  logic                st_emit, st_lit, st_dq;
  gts_pkg::tok_kind_e  st_kind;
  gts_pkg::scan_mode_e st_mode;

  logic                use_start;
  logic [1:0]          start_pos;

  assign is_alpha = (input_byte_i >= 8'h61 && input_byte_i <= 8'h7A) ||
                    (input_byte_i >= 8'h41 && input_byte_i <= 8'h5A);
  assign is_digit = input_byte_i >= 8'h30 && input_byte_i <= 8'h39;
  assign is_space_any = (input_byte_i == gts_pkg::ChSpace) ||
                        (input_byte_i >= gts_pkg::ChTab && input_byte_i <= gts_pkg::ChCr);
  assign is_ident_ch = is_alpha || is_digit || (input_byte_i == gts_pkg::ChUnderscore);
  assign lit_close = input_byte_i == (quote_q ? gts_pkg::ChDquote : gts_pkg::ChSquote);

  always_comb begin
    st_emit = 1'b1;
    st_kind = gts_pkg::TkIllegal;
    st_mode = gts_pkg::ModeIdle;
    st_lit  = 1'b0;
    st_dq   = 1'b0;
    unique case (input_byte_i)
      gts_pkg::ChSpace, gts_pkg::ChTab, gts_pkg::ChNewline: begin
        st_emit = 1'b0;
        st_mode = gts_pkg::ModeSpace;
      end
      gts_pkg::ChOpen:  st_kind = gts_pkg::TkOpen;
      gts_pkg::ChClose: st_kind = gts_pkg::TkClose;
      gts_pkg::ChBar:   st_kind = gts_pkg::TkBar;
      gts_pkg::ChSemi:  st_kind = gts_pkg::TkSemi;
      gts_pkg::ChColon: begin
        st_emit = 1'b0;
        st_mode = gts_pkg::ModeColon1;
      end
      gts_pkg::ChSquote: begin
        st_emit = 1'b0;
        st_lit  = 1'b1;
        st_mode = gts_pkg::ModeLit;
      end
      gts_pkg::ChDquote: begin
        st_emit = 1'b0;
        st_lit  = 1'b1;
        st_dq   = 1'b1;
        st_mode = gts_pkg::ModeLit;
      end
      default: begin
        if (is_alpha || input_byte_i == gts_pkg::ChUnderscore) begin
          st_kind = gts_pkg::TkText;
          st_mode = gts_pkg::ModeIdent;
        end
      end
    endcase
  end

  always_comb begin
    res_o      = '0;
    res_o.text = input_byte_i;
    mode_d     = mode_q;
    quote_d    = quote_q;
    use_start  = 1'b0;
    start_pos  = 2'd0;
    if (fire_i) begin
      if (end_of_text_i) begin
        mode_d = gts_pkg::ModeIdle;
        unique case (mode_q)
          gts_pkg::ModeIdent: begin
            res_o.kind[0] = gts_pkg::TkIdent;
            res_o.kind[1] = gts_pkg::TkEnd;
            res_o.cnt     = 2'd2;
          end
          gts_pkg::ModeLit, gts_pkg::ModeColon1: begin
            res_o.kind[0] = gts_pkg::TkIllegal;
            res_o.kind[1] = gts_pkg::TkEnd;
            res_o.cnt     = 2'd2;
          end
          gts_pkg::ModeColon2: begin
            res_o.kind[0] = gts_pkg::TkIllegal;
            res_o.kind[1] = gts_pkg::TkIllegal;
            res_o.kind[2] = gts_pkg::TkEnd;
            res_o.cnt     = 2'd3;
          end
          default: begin
            res_o.kind[0] = gts_pkg::TkEnd;
            res_o.cnt     = 2'd1;
          end
        endcase
      end else begin
        unique case (mode_q)
          gts_pkg::ModeSpace: begin
            use_start = !is_space_any;
          end
          gts_pkg::ModeIdent: begin
            if (is_ident_ch) begin
              res_o.kind[0] = gts_pkg::TkText;
              res_o.cnt     = 2'd1;
            end else begin
              res_o.kind[0] = gts_pkg::TkIdent;
              res_o.cnt     = 2'd1;
              use_start     = 1'b1;
              start_pos     = 2'd1;
            end
          end
          gts_pkg::ModeLit: begin
            res_o.cnt = 2'd1;
            if (lit_close) begin
              res_o.kind[0] = gts_pkg::TkLit;
              mode_d        = gts_pkg::ModeIdle;
            end else begin
              res_o.kind[0] = gts_pkg::TkText;
            end
          end
          gts_pkg::ModeColon1: begin
            if (input_byte_i == gts_pkg::ChColon) begin
              mode_d = gts_pkg::ModeColon2;
            end else begin
              res_o.kind[0] = gts_pkg::TkIllegal;
              res_o.cnt     = 2'd1;
              use_start     = 1'b1;
              start_pos     = 2'd1;
            end
          end
          gts_pkg::ModeColon2: begin
            res_o.cnt = 2'd1;
            if (input_byte_i == gts_pkg::ChEquals) begin
              res_o.kind[0] = gts_pkg::TkAssign;
              mode_d        = gts_pkg::ModeIdle;
            end else if (input_byte_i == gts_pkg::ChColon) begin
              // third colon: flag one, keep the pair pending
              res_o.kind[0] = gts_pkg::TkIllegal;
            end else begin
              res_o.kind[0] = gts_pkg::TkIllegal;
              res_o.kind[1] = gts_pkg::TkIllegal;
              res_o.cnt     = 2'd2;
              use_start     = 1'b1;
              start_pos     = 2'd2;
            end
          end
          default: begin
            use_start = 1'b1;
          end
        endcase
        // breaking byte is rescanned as a token start
        if (use_start) begin
          mode_d = st_mode;
          if (st_lit) begin
            quote_d = st_dq;
          end
          if (st_emit) begin
            res_o.kind[start_pos] = st_kind;
            res_o.cnt             = start_pos + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= gts_pkg::ModeIdle;
      quote_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      quote_q <= quote_d;
    end
  end

endmodule

/* rtl/gts_result_fifo.sv */
// result queue taking up to three results per cycle and giving one while out_ready_i is high
`include "grammar_token_scanner_assert.svh"
module gts_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gts_pkg::dec_res_t   res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gts_pkg::res_entry_t out_entry_o
);

  localparam int unsigned PtrW = gts_pkg::PtrW;
  localparam int unsigned CntW = gts_pkg::CntW;

  gts_pkg::res_entry_t mem_q [gts_pkg::FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;
  gts_pkg::res_entry_t wr_entry [gts_pkg::MaxRes];

  assign room_o      = cnt_q <= CntW'(gts_pkg::FifoDepth - gts_pkg::MaxRes);
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    for (int i = 0; i < gts_pkg::MaxRes; i++) begin
      wr_entry[i].kind = res_i.kind[i];
      wr_entry[i].text = (res_i.kind[i] == gts_pkg::TkText) ? res_i.text : 8'h00;
      wr_entry[i].last = (gts_pkg::ResCntW'(i) + 2'd1) == res_i.cnt;
    end
    wr_ptr_d = wr_ptr_q + PtrW'(res_i.cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(res_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < gts_pkg::MaxRes; i++) begin
      if (gts_pkg::ResCntW'(i) < res_i.cnt) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= wr_entry[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `GTS_ASSERT(a_cnt_bound, cnt_q <= CntW'(gts_pkg::FifoDepth), "result queue overflow")
  `GTS_ASSERT_NEXT(a_push_only_with_room, res_i.cnt != '0 && !pop, cnt_q == $past(cnt_q) + CntW'($past(res_i.cnt)), "push count lost")
  `GTS_ASSERT_NEXT(a_pop_drains, pop && res_i.cnt == '0, cnt_q == $past(cnt_q) - CntW'(1), "pop count lost")
  `GTS_ASSERT(a_ptr_gap, wr_ptr_q == rd_ptr_q + PtrW'(cnt_q), "pointers disagree with fill count")

endmodule

/* rtl/grammar_token_scanner.sv */
// grammar_token_scanner: streaming tokenizer for grammar text
//
// Input channel (in_valid_i/in_ready_o): one byte of text per transfer, or a
// transfer with end_of_text_i set that flushes any pending token and emits
// the end token. Output channel (out_valid_o/out_ready_i): one result per
// transfer (token_kind_o, text_byte_o, last_of_run_o); last_of_run_o marks
// the final result caused by an input byte. Bytes that cause no result
// (whitespace, a quote, a first colon) produce no output transfer.
// The first result of a byte is written into the result queue at its input
// transfer and offered once the results ahead of it have left. One input
// byte is taken every cycle while in_ready_o is high; results leave at one
// per cycle while out_ready_i is high. The scan state updates in the same
// cycle as the input transfer, and results go into an 8-entry result queue;
// in_ready_o is high while at least three entries are free, so a stalled
// receiver holds input once more than five entries are taken. Reset returns
// the scanner to between tokens and empties the queue.
module grammar_token_scanner (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] input_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_kind_o,
  output logic [7:0] text_byte_o,
  output logic       last_of_run_o
);

  logic                in_fire;
  gts_pkg::dec_res_t   dec_res;
  gts_pkg::res_entry_t out_entry;

  assign in_fire = in_valid_i && in_ready_o;

  gts_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .input_byte_i  (input_byte_i),
    .end_of_text_i (end_of_text_i),
    .res_o         (dec_res)
  );

  gts_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (dec_res),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_entry_o (out_entry)
  );

  assign token_kind_o  = out_entry.kind;
  assign text_byte_o   = out_entry.text;
  assign last_of_run_o = out_entry.last;

endmodule
